[hdl/c2s_pkg.sv]
`default_nettype none
package c2s_pkg;

  localparam int CORDIC_STAGES = 32;
  localparam int GUARD_BITS    = 8;
  localparam int SQ_W          = 66;
  // Magnitudes are at most 2^31, so one guard-extended CORDIC value needs
  // 40 bits plus one sign bit and some headroom for the gain.
  localparam int CW            = 43;
  localparam int AW            = 32;
  localparam int SHIFT_W       = 6;
  localparam int RHO_STEPS     = 32;
  localparam int RAD_STEPS     = 33;

  localparam logic signed [AW-1:0] ANG_PI      = 32'sd1686629713;
  localparam logic signed [AW-1:0] ANG_HALF_PI = 32'sd843314857;

  function automatic logic signed [AW-1:0] atan_tab(input int i);
    logic signed [AW-1:0] t;
    case (i)
      0: t = 32'sd421657428;
      1: t = 32'sd248918915;
      2: t = 32'sd131521918;
      3: t = 32'sd66762579;
      4: t = 32'sd33510843;
      5: t = 32'sd16771758;
      6: t = 32'sd8387925;
      7: t = 32'sd4194219;
      8: t = 32'sd2097141;
      9: t = 32'sd1048575;
      default: begin
        if (i >= 10 && i < 30) t = 32'sd1 <<< (29 - i);
        else t = '0;
      end
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

[hdl/c2s_isqrt_step.sv]
`default_nettype none
// One digit step of the restoring integer square root.
module c2s_isqrt_step (
  input  wire logic [c2s_pkg::SQ_W-1:0] op_i,
  input  wire logic [c2s_pkg::SQ_W-1:0] res_i,
  input  wire logic [c2s_pkg::SQ_W-1:0] one_i,
  output logic [c2s_pkg::SQ_W-1:0]      op_o,
  output logic [c2s_pkg::SQ_W-1:0]      res_o
);
  logic [c2s_pkg::SQ_W-1:0] trial;
  always_comb begin
    trial = res_i + one_i;
    if (op_i >= trial) begin
      op_o  = op_i - trial;
      res_o = (res_i >> 1) + one_i;
    end else begin
      op_o  = op_i;
      res_o = res_i >> 1;
    end
  end
endmodule
`default_nettype wire

[hdl/c2s_cordic_step.sv]
`default_nettype none
// One CORDIC vectoring micro-rotation; shift and angle are tied off per stage.
module c2s_cordic_step (
  input  wire logic [c2s_pkg::SHIFT_W-1:0]   shift_i,
  input  wire logic signed [c2s_pkg::AW+1:0] t_i,
  input  wire logic signed [c2s_pkg::CW-1:0] u_i,
  input  wire logic signed [c2s_pkg::CW-1:0] v_i,
  input  wire logic signed [c2s_pkg::AW+1:0] a_i,
  output logic signed [c2s_pkg::CW-1:0]      u_o,
  output logic signed [c2s_pkg::CW-1:0]      v_o,
  output logic signed [c2s_pkg::AW+1:0]      a_o
);
  logic signed [c2s_pkg::CW-1:0] du, dv;
  always_comb begin
    du = v_i >>> shift_i;
    dv = u_i >>> shift_i;
    if (!v_i[c2s_pkg::CW-1]) begin
      u_o = u_i + du;
      v_o = v_i - dv;
      a_o = a_i + t_i;
    end else begin
      u_o = u_i - du;
      v_o = v_i + dv;
      a_o = a_i - t_i;
    end
  end
endmodule
`default_nettype wire

[hdl/cartesian_to_spherical_core.sv]
`default_nettype none
// Cartesian to spherical converter. One vector is accepted every cycle while
// the output is not stalled, and its result word passes through an input
// stage for the magnitudes and squares, two square-root chains (rho over the
// xy plane, then radius) of one digit per register stage, a CORDIC chain for
// the polar angle of one micro-rotation per stage, and the output register.
// The azimuth CORDIC runs alongside the square roots. All stages advance
// together on a shared enable; a stall at the output freezes the whole
// pipeline and the input.
module cartesian_to_spherical_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_x_coord,
  input  wire logic signed [31:0] in_y_coord,
  input  wire logic signed [31:0] in_z_coord,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [31:0]             out_radius,
  output logic signed [31:0]      out_azimuth,
  output logic [30:0]             out_polar_angle
);
  localparam int SQ_W = c2s_pkg::SQ_W;
  localparam int CW   = c2s_pkg::CW;
  localparam int AW   = c2s_pkg::AW;
  localparam int SW   = c2s_pkg::SHIFT_W;
  localparam int GB   = c2s_pkg::GUARD_BITS;
  localparam int NC   = c2s_pkg::CORDIC_STAGES;
  localparam int NR   = c2s_pkg::RHO_STEPS;
  localparam int ND   = c2s_pkg::RAD_STEPS;
  localparam int L1   = NR + ND;          // square-root section length
  localparam int NT   = L1 + NC;          // total stages after input reg

  typedef struct packed {
    logic xz, xneg, ypos, yneg, yz, zz, zneg;
  } flags_t;

  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Input stage: magnitudes and squares.
  logic          v0_r;
  flags_t        f0_r;
  logic [31:0]   ax0_r, ay0_r, az0_r;
  logic [SQ_W-1:0] sxy0_r, szz0_r;

  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    logic [32:0] e;
    e = {a[31], a};
    return e[32] ? 32'(-e) : 32'(e);
  endfunction

  logic [31:0] ax_c, ay_c, az_c;
  always_comb begin
    ax_c = mag32(in_x_coord);
    ay_c = mag32(in_y_coord);
    az_c = mag32(in_z_coord);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_valid;
    if (adv) begin
      f0_r.xz   <= in_x_coord == 0;
      f0_r.xneg <= in_x_coord[31];
      f0_r.ypos <= !in_y_coord[31] && in_y_coord != 0;
      f0_r.yneg <= in_y_coord[31];
      f0_r.yz   <= in_y_coord == 0;
      f0_r.zz   <= in_z_coord == 0;
      f0_r.zneg <= in_z_coord[31];
      ax0_r <= ax_c; ay0_r <= ay_c; az0_r <= az_c;
      sxy0_r <= SQ_W'({32'd0, ax_c} * {32'd0, ax_c}) +
                SQ_W'({32'd0, ay_c} * {32'd0, ay_c});
      szz0_r <= SQ_W'({32'd0, az_c} * {32'd0, az_c});
    end
  end

  // Pipeline registers indexed by stage.
  logic          vp_r  [NT+1];
  flags_t        fp_r  [NT+1];
  logic [SQ_W-1:0] op_r [L1+1];
  logic [SQ_W-1:0] res_r[L1+1];
  logic [SQ_W-1:0] szz_r[NR+1];
  logic [SQ_W-1:0] sxyd_r [NR+1];
  logic [31:0]   az_r  [L1+1];
  logic [31:0]   rho_r [NR:L1];
  logic [31:0]   rad_r [L1:NT];
  logic signed [AW-1:0] azi_r [NC:NT];
  // Azimuth CORDIC state (stages 1..NC).
  logic signed [CW-1:0]   au_r [NC+1];
  logic signed [CW-1:0]   av_r [NC+1];
  logic signed [AW+1:0]   aa_r [NC+1];
  // Polar CORDIC state.
  logic signed [CW-1:0]   pu_r [NC+1];
  logic signed [CW-1:0]   pv_r [NC+1];
  logic signed [AW+1:0]   pa_r [NC+1];

  assign vp_r[0] = v0_r;
  assign fp_r[0] = f0_r;

  for (genvar i = 1; i <= NT; i++) begin : g_flow
    always_ff @(posedge clk) begin
      if (!rst_n) vp_r[i] <= 1'b0;
      else if (adv) vp_r[i] <= vp_r[i-1];
      if (adv) fp_r[i] <= fp_r[i-1];
    end
  end

  // Azimuth CORDIC, stages 1..NC.
  assign au_r[0] = CW'({ax0_r, {GB{1'b0}}});
  assign av_r[0] = CW'({ay0_r, {GB{1'b0}}});
  assign aa_r[0] = '0;

  logic signed [AW-1:0] azi_fix;
  for (genvar i = 0; i < NC; i++) begin : g_az
    localparam logic [SW-1:0] SH = SW'(i);
    localparam logic signed [AW+1:0] T = (AW+2)'(c2s_pkg::atan_tab(i));
    logic signed [CW-1:0] un, vn;
    logic signed [AW+1:0] an;
    c2s_cordic_step u_st (
      .shift_i(SH), .t_i(T),
      .u_i(au_r[i]), .v_i(av_r[i]), .a_i(aa_r[i]),
      .u_o(un), .v_o(vn), .a_o(an));
    always_ff @(posedge clk) begin
      if (adv) begin
        au_r[i+1] <= un; av_r[i+1] <= vn; aa_r[i+1] <= an;
      end
    end
  end

  always_comb begin
    logic signed [AW+1:0] a;
    a = aa_r[NC];
    if (fp_r[NC].yz) a = '0;
    else if (a < 0) a = '0;
    else if (a > (AW+2)'(c2s_pkg::ANG_HALF_PI)) a = (AW+2)'(c2s_pkg::ANG_HALF_PI);
    if (fp_r[NC].xz)
      azi_fix = fp_r[NC].ypos ? c2s_pkg::ANG_HALF_PI : -c2s_pkg::ANG_HALF_PI;
    else if (!fp_r[NC].xneg)
      azi_fix = fp_r[NC].yneg ? -AW'(a) : AW'(a);
    else if (fp_r[NC].ypos)
      azi_fix = c2s_pkg::ANG_PI - AW'(a);
    else if (fp_r[NC].yneg)
      azi_fix = AW'(a) - c2s_pkg::ANG_PI;
    else
      azi_fix = -c2s_pkg::ANG_PI;
  end

  assign azi_r[NC] = azi_fix;
  for (genvar i = NC + 1; i <= NT; i++) begin : g_azi
    always_ff @(posedge clk) begin
      if (adv) azi_r[i] <= azi_r[i-1];
    end
  end

  // Copy of x^2 + y^2 alongside the rho root for the radius root.
  assign sxyd_r[0] = sxy0_r;
  for (genvar i = 1; i <= NR; i++) begin : g_sxyd
    always_ff @(posedge clk) begin
      if (adv) sxyd_r[i] <= sxyd_r[i-1];
    end
  end

  // Rho square root, stages 1..NR; then radius square root NR+1..L1.
  assign op_r[0]  = sxy0_r;
  assign res_r[0] = '0;
  assign szz_r[0] = szz0_r;
  assign az_r[0]  = az0_r;

  for (genvar i = 0; i < L1; i++) begin : g_sq
    localparam int K = (i < NR) ? (NR - 1 - i) : (ND - 1 - (i - NR));
    localparam logic [SQ_W-1:0] ONE = SQ_W'(1) << (2 * K);
    logic [SQ_W-1:0] op_in, res_in, op_n, res_n;
    if (i == NR) begin : g_rad_start
      // The radius root starts over from x^2 + y^2 + z^2.
      assign op_in  = sxyd_r[NR] + szz_r[NR];
      assign res_in = '0;
    end else begin : g_pass
      assign op_in  = op_r[i];
      assign res_in = res_r[i];
    end
    c2s_isqrt_step u_sq (.op_i(op_in), .res_i(res_in), .one_i(ONE),
                         .op_o(op_n), .res_o(res_n));
    always_ff @(posedge clk) begin
      if (adv) begin
        op_r[i+1]  <= op_n;
        res_r[i+1] <= res_n;
        az_r[i+1]  <= az_r[i];
      end
    end
    if (i < NR) begin : g_szz
      always_ff @(posedge clk) begin
        if (adv) szz_r[i+1] <= szz_r[i];
      end
    end
    if (i == NR - 1) begin : g_rho_take
      always_ff @(posedge clk) begin
        if (adv) rho_r[NR] <= 32'(res_n);
      end
    end else if (i >= NR) begin : g_rho_keep
      always_ff @(posedge clk) begin
        if (adv) rho_r[i+1] <= rho_r[i];
      end
    end
  end

  assign rad_r[L1] = 32'(res_r[L1]);
  for (genvar i = L1 + 1; i <= NT; i++) begin : g_rad
    always_ff @(posedge clk) begin
      if (adv) rad_r[i] <= rad_r[i-1];
    end
  end

  // Polar CORDIC, stages L1+1..NT.
  assign pu_r[0] = CW'({az_r[L1], {GB{1'b0}}});
  assign pv_r[0] = CW'({rho_r[L1], {GB{1'b0}}});
  assign pa_r[0] = '0;
  for (genvar i = 0; i < NC; i++) begin : g_po
    localparam logic [SW-1:0] SH = SW'(i);
    localparam logic signed [AW+1:0] T = (AW+2)'(c2s_pkg::atan_tab(i));
    logic signed [CW-1:0] un, vn;
    logic signed [AW+1:0] an;
    c2s_cordic_step u_st (
      .shift_i(SH), .t_i(T),
      .u_i(pu_r[i]), .v_i(pv_r[i]), .a_i(pa_r[i]),
      .u_o(un), .v_o(vn), .a_o(an));
    always_ff @(posedge clk) begin
      if (adv) begin
        pu_r[i+1] <= un; pv_r[i+1] <= vn; pa_r[i+1] <= an;
      end
    end
  end

  // rho == 0 at the polar stage input must be remembered.
  logic rz_r [NC+1];
  assign rz_r[0] = rho_r[L1] == '0;
  for (genvar i = 1; i <= NC; i++) begin : g_rz
    always_ff @(posedge clk) begin
      if (adv) rz_r[i] <= rz_r[i-1];
    end
  end

  logic [30:0] pol_fix;
  always_comb begin
    logic signed [AW+1:0] a;
    a = pa_r[NC];
    if (rz_r[NC]) a = '0;
    else if (a < 0) a = '0;
    else if (a > (AW+2)'(c2s_pkg::ANG_HALF_PI)) a = (AW+2)'(c2s_pkg::ANG_HALF_PI);
    if (fp_r[NT].zz) pol_fix = 31'(c2s_pkg::ANG_HALF_PI);
    else if (fp_r[NT].zneg) pol_fix = 31'(c2s_pkg::ANG_PI - AW'(a));
    else pol_fix = 31'(a);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (adv) out_valid <= vp_r[NT];
    if (adv) begin
      out_radius      <= rad_r[NT];
      out_azimuth     <= azi_r[NT];
      out_polar_angle <= pol_fix;
    end
  end
endmodule
`default_nettype wire
